>>> design/alar_pkg.sv
// Shared types, widths and codes for the array list with positional remove.
package alar_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ITEM_CNT_W = 11;

  // Entry index and fill count derive from the capacity.
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // First reduction level folds this many cells into one group register.
  localparam int unsigned GROUP   = 32;
  localparam int unsigned NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [FUNC_W-1:0]       func_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ITEM_CNT_W-1:0]   item_cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_POS = 2'd2
  } status_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic append;
    logic remove;
    idx_t wr_idx;
    idx_t rm_idx;
    key_t key;
  } cell_ctrl_t;

endpackage

>>> design/alar_cell.sv
// One storage cell of the list: holds a key, loads on append, takes its neighbor on remove.
module alar_cell (
  input  logic              clk_i,
  input  alar_pkg::idx_t    cell_idx_i,
  input  alar_pkg::cell_ctrl_t ctrl_i,
  input  alar_pkg::key_t    next_key_i,
  output alar_pkg::key_t    key_o,
  output alar_pkg::key_t    sel_key_o
);
  import alar_pkg::*;

  key_t key_q;
  key_t key_d;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.append && (ctrl_i.wr_idx == cell_idx_i)) begin
      key_d = ctrl_i.key;
    end else if (ctrl_i.remove && (cell_idx_i >= ctrl_i.rm_idx)) begin
      // close the gap: every cell at or above the removed slot takes its upper neighbor
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o     = key_q;
  assign sel_key_o = (ctrl_i.rm_idx == cell_idx_i) ? key_q : '0;

endmodule

>>> design/array_list_append_remove_at.sv
// Top level: controller, chain of key cells and two-level removed-key select tree.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, func_i, key_i,     | into block
//           | position_i                                 |
//   out     | out_valid_o, out_ready_i, status_o,        | out of block
//           | removed_key_o, item_count_o, is_empty_o    |
//
// An item goes through accept, execute (cells shift or load, group
// registers capture the selected key) and reduce (group registers fold into the
// result register). A new item is accepted only after the previous one has
// left reduce. The result register holds a finished result while the next
// item is accepted; reduce stalls only while that register is still full.
// Reset empties the list at once; cell contents are left as is.
module array_list_append_remove_at (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  alar_pkg::func_t      func_i,
  input  alar_pkg::key_t       key_i,
  input  alar_pkg::pos_t       position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [alar_pkg::STATUS_W-1:0] status_o,
  output alar_pkg::key_t       removed_key_o,
  output alar_pkg::item_cnt_t  item_count_o,
  output logic                 is_empty_o
);
  import alar_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE
  } state_e;

  state_e      state_q;
  func_t       func_q;
  key_t        key_q;
  pos_t        pos_q;
  cnt_t        count_q;
  cnt_t        count_d;
  status_e     status_d;
  status_e     st_q;
  logic        rm_ok_d;
  logic        rm_ok_q;
  logic        out_valid_q;
  status_e     status_q;
  key_t        removed_q;
  item_cnt_t   item_cnt_q;
  logic        empty_q;
  cell_ctrl_t  ctrl;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] idx_full;

  key_t cell_key [NGROUPS*GROUP];
  key_t sel_key  [NGROUPS*GROUP];
  key_t grp_d    [NGROUPS];
  key_t grp_q    [NGROUPS];
  key_t removed_d;

  // Execute-stage decode
  always_comb begin
    pos_ext  = CMP_W'(pos_q);
    cnt_ext  = CMP_W'(count_q);
    idx_full = pos_ext - CMP_W'(1);
    count_d  = count_q;
    status_d = STATUS_DONE;
    rm_ok_d  = 1'b0;
    ctrl.append = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.wr_idx = count_q[IDX_W-1:0];
    ctrl.rm_idx = idx_full[IDX_W-1:0];
    ctrl.key    = key_q;
    unique case (func_q)
      FUNC_CLEAR: begin
        count_d = '0;
      end
      FUNC_APPEND: begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          status_d = STATUS_FULL;
        end else begin
          ctrl.append = (state_q == ST_EXEC);
          count_d     = count_q + CNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if ((pos_q == '0) || (pos_ext > cnt_ext)) begin
          status_d = STATUS_BAD_POS;
        end else begin
          ctrl.remove = (state_q == ST_EXEC);
          rm_ok_d     = 1'b1;
          count_d     = count_q - CNT_W'(1);
        end
      end
      default: begin
        // unused code: leave the list alone
      end
    endcase
  end

  // Cell chain; slots past the capacity read as zero
  for (genvar i = 0; i < NGROUPS*GROUP; i++) begin : g_cell
    if (i < CAPACITY) begin : g_real
      key_t nxt;
      if (i + 1 < CAPACITY) begin : g_nxt
        assign nxt = cell_key[i+1];
      end else begin : g_end
        assign nxt = '0;
      end
      alar_cell u_cell (
        .clk_i      (clk_i),
        .cell_idx_i (IDX_W'(i)),
        .ctrl_i     (ctrl),
        .next_key_i (nxt),
        .key_o      (cell_key[i]),
        .sel_key_o  (sel_key[i])
      );
    end else begin : g_pad
      assign cell_key[i] = '0;
      assign sel_key[i]  = '0;
    end
  end

  // First fold level: OR the one-hot selected keys inside each group
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_d[g] = grp_d[g] | sel_key[g*GROUP + j];
      end
    end
  end

  // Second fold level
  always_comb begin
    removed_d = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      removed_d = removed_d | grp_q[g];
    end
    if (!rm_ok_q) begin
      removed_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      grp_q <= grp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= '0;
      key_q       <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      st_q        <= STATUS_DONE;
      rm_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_DONE;
      removed_q   <= '0;
      item_cnt_q  <= '0;
      empty_q     <= 1'b1;
    end else begin
      // drop the result once transferred, unless reduce refills it this cycle
      if (out_valid_q && out_ready_i && (state_q != ST_REDUCE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            key_q   <= key_i;
            pos_q   <= position_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count_q <= count_d;
          st_q    <= status_d;
          rm_ok_q <= rm_ok_d;
          state_q <= ST_REDUCE;
        end
        ST_REDUCE: begin
          // hold until the result register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= st_q;
            removed_q   <= removed_d;
            item_cnt_q  <= ITEM_CNT_W'(count_q);
            empty_q     <= (count_q == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign removed_key_o = removed_q;
  assign item_count_o  = item_cnt_q;
  assign is_empty_o    = empty_q;

endmodule
